>>> rtl/core/rbirdq_pkg.sv
// ----------------------------------------------------------------------------
// rbirdq_pkg
// Shared types and constants of the input-restricted deque: sizes, opcodes,
// status codes and the structs that run along the row of storage cells.
// ----------------------------------------------------------------------------
package rbirdq_pkg;

  // Number of entries and stored word width
  localparam int unsigned Depth     = 32;
  localparam int unsigned DataWidth = 32;

  // Field widths of the stream payloads
  localparam int unsigned OpW     = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;

  // Stored bits: a word keeps at most its low DataWidth bits
  localparam int unsigned StoreW = (DataWidth < WordW) ? DataWidth : WordW;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InBits    = OpW + WordW;
  localparam int unsigned InDataW   = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits   = StatusW + WordW + 2;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR     = 2'd0,
    OP_PUSH_REAR = 2'd1,
    OP_POP_REAR  = 2'd2,
    OP_POP_FRONT = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell; at most one strobe is set
  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop_rear;
    logic              pop_front;
    logic [StoreW-1:0] word;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic [StoreW-1:0] data;
  } cell_link_t;

endpackage

>>> rtl/core/rbirdq_cell.sv
// ----------------------------------------------------------------------------
// rbirdq_cell
// One storage cell of the deque row. Cell positions count from the front:
// a push fills the first free cell, a rear pop drops the last valid cell and
// a front pop shifts every cell one place toward the front.
// ----------------------------------------------------------------------------
module rbirdq_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rbirdq_pkg::cell_cmd_t  cmd_i,
  input  logic                   left_valid_i,  // neighbor toward the front
  input  rbirdq_pkg::cell_link_t right_i,       // neighbor toward the rear
  output rbirdq_pkg::cell_link_t link_o
);
  import rbirdq_pkg::*;

  logic              valid_q, valid_d;
  logic [StoreW-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.push) begin
      // first free cell behind a valid one takes the word
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        data_d  = cmd_i.word;
      end
    end else if (cmd_i.pop_rear) begin
      if (valid_q && !right_i.valid) begin
        valid_d = 1'b0;
      end
    end else if (cmd_i.pop_front) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.data  = data_q;

endmodule

>>> rtl/core/ring_buffer_input_restricted_deque_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_input_restricted_deque_unit
// Input-restricted deque: words enter at the rear and leave from either end.
// ----------------------------------------------------------------------------
// Output: an accepted request's result is registered, ready the next cycle.
// Throughput: 1 request per cycle while results are taken; all cells update
//   together and the output register frees up whenever its result is taken.
// Reset: rst_ni clears all cell valid bits (queue empty) and the output
//   valid bit; stored words and output data are left as they are.
// ----------------------------------------------------------------------------
module ring_buffer_input_restricted_deque_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request: [1:0] opcode, [33:2] push_value, upper bits zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rbirdq_pkg::InDataW-1:0]  s_axis_tdata,
  // result: [1:0] status, [33:2] popped_value, [34] is_empty, [35] is_full,
  // upper bits zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rbirdq_pkg::OutDataW-1:0] m_axis_tdata
);
  import rbirdq_pkg::*;

  // Unpack the request
  opcode_e           op;
  logic [WordW-1:0]  push_value;
  logic              req_fire;

  assign op         = opcode_e'(s_axis_tdata[OpW-1:0]);
  assign push_value = s_axis_tdata[OpW +: WordW];

  // Output register frees up when empty or when its result leaves this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  // Row of cells, front at index 0
  cell_link_t        links [Depth];
  cell_cmd_t         cmd;
  logic              is_empty, is_full;

  assign is_empty = !links[0].valid;
  assign is_full  = links[Depth-1].valid;

  // Rear word: the last valid cell, found locally by each cell and OR-merged
  logic [StoreW-1:0] rear_word;
  always_comb begin
    rear_word = '0;
    for (int unsigned i = 0; i < Depth; i++) begin
      if (links[i].valid && (i == Depth - 1 || !links[(i + 1) % Depth].valid)) begin
        rear_word = rear_word | links[i].data;
      end
    end
  end

  // Decode the request into cell commands; refused requests change nothing
  status_e           status;
  logic [StoreW-1:0] popped;
  logic              empty_after, full_after;

  always_comb begin
    cmd         = '0;
    cmd.word    = push_value[StoreW-1:0];
    status      = ST_OK;
    popped      = '0;
    empty_after = is_empty;
    full_after  = is_full;
    unique case (op)
      OP_CLEAR: begin
        cmd.clear   = req_fire;
        empty_after = 1'b1;
        full_after  = 1'b0;
      end
      OP_PUSH_REAR: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.push    = req_fire;
          empty_after = 1'b0;
          full_after  = links[Depth-2].valid;
        end
      end
      OP_POP_REAR, OP_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.pop_rear  = req_fire && (op == OP_POP_REAR);
          cmd.pop_front = req_fire && (op == OP_POP_FRONT);
          popped        = (op == OP_POP_REAR) ? rear_word : links[0].data;
          empty_after   = !links[1].valid;
          full_after    = 1'b0;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic       left_valid;
    cell_link_t right;
    if (g == 0) begin : g_front
      assign left_valid = 1'b1;
    end else begin : g_inner
      assign left_valid = links[g-1].valid;
    end
    if (g == Depth - 1) begin : g_rear
      assign right = '0;
    end else begin : g_mid
      assign right = links[g+1];
    end
    rbirdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_valid_i(left_valid),
      .right_i     (right),
      .link_o      (links[g])
    );
  end

  // Output register: hold the result until the master side takes it
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [WordW-1:0]    popped_ext;

  assign popped_ext = WordW'(popped);

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (req_fire) begin
      m_valid_d = 1'b1;
      m_data_d  = OutDataW'({full_after, empty_after, popped_ext, status});
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
